[design/lct_pkg.sv]
// ----------------------------------------------------------------------------
// lct_pkg: shared types and constants for the LFU cache table
// Entry layout in the slot memory, scan control/result bundles and codes.
// ----------------------------------------------------------------------------
package lct_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W       = 5;
   localparam int CMP_W       = (FILL_W > CAP_W) ? FILL_W : CAP_W;
   localparam int WORD_W      = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [WORD_W-1:0] MISS_VALUE = {WORD_W{1'b1}};   // -1
   localparam logic [WORD_W-1:0] SAT_MAX    = {WORD_W{1'b1}};

   typedef enum logic {
      FUNC_GET = 1'b0,
      FUNC_PUT = 1'b1
   } func_type;

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] data;
      logic [WORD_W-1:0] use_count;
      logic [WORD_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             clear;   // start of a new transaction
      logic             load;    // read data valid this cycle
      logic [IDX_W-1:0] idx;     // slot whose data is on the read port
   } scan_ctl_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      entry_type        hit_entry;
      logic             vic_found;
      logic [IDX_W-1:0] vic_idx;
      entry_type        vic_entry;
   } scan_res_type;

endpackage

[design/lct_ram.sv]
// ----------------------------------------------------------------------------
// lct_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lct_scan.sv]
// ----------------------------------------------------------------------------
// lct_scan: key match and replacement victim tracker
// Consumes one slot per cycle from the memory read port; keeps the first
// matching slot and the lowest (use count, stamp, slot) valid slot.
// ----------------------------------------------------------------------------
module lct_scan import lct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      scan_ctl,
   input  logic              slot_valid,
   input  entry_type         rd_entry,
   input  logic [WORD_W-1:0] lookup_key,
   output scan_res_type      scan_res
);

   scan_res_type res_ff;
   scan_res_type res_in;
   logic         older;

   // strict compare keeps the lowest slot on a full tie
   assign older = (rd_entry.use_count < res_ff.vic_entry.use_count) ||
                  ((rd_entry.use_count == res_ff.vic_entry.use_count) &&
                   (rd_entry.stamp < res_ff.vic_entry.stamp));

   always_comb begin
      res_in = res_ff;
      if (scan_ctl.clear) begin
         res_in.hit       = 1'b0;
         res_in.vic_found = 1'b0;
      end else if (scan_ctl.load && slot_valid) begin
         if (!res_ff.hit && (rd_entry.key == lookup_key)) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = scan_ctl.idx;
            res_in.hit_entry = rd_entry;
         end
         if (!res_ff.vic_found || older) begin
            res_in.vic_found = 1'b1;
            res_in.vic_idx   = scan_ctl.idx;
            res_in.vic_entry = rd_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit       <= 1'b0;
         res_ff.vic_found <= 1'b0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign scan_res = res_ff;

endmodule

[design/lct_control.sv]
// ----------------------------------------------------------------------------
// lct_control: transaction sequencer and write-back for the cache table
// Runs the slot scan, then in the write-back state updates the slot memory, valid
// bits, fill level and access clock as the request needs and loads the result register.
// ----------------------------------------------------------------------------
module lct_control import lct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [WORD_W-1:0] req_key,
   input  logic [WORD_W-1:0] req_value,
   // capacity register
   input  logic [CAP_W-1:0]  cap,
   // slot memory
   output logic              ram_we,
   output logic [IDX_W-1:0]  ram_waddr,
   output entry_type         ram_wdata,
   output logic [IDX_W-1:0]  ram_raddr,
   // scan unit
   output scan_ctl_type      scan_ctl,
   output logic              scan_valid,
   output logic [WORD_W-1:0] scan_key,
   input  scan_res_type      scan_res,
   // response
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WORD_W-1:0] rsp_read_value,
   output logic              rsp_evicted,
   output logic [WORD_W-1:0] rsp_evicted_key
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [FILL_W-1:0]        cnt_ff, cnt_in;
   logic [MAX_ENTRIES-1:0]   valid_ff, valid_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [WORD_W-1:0]        clock_ff, clock_in;
   logic                     func_ff, func_in;
   logic [WORD_W-1:0]        key_ff, key_in;
   logic [WORD_W-1:0]        value_ff, value_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [WORD_W-1:0]        rsp_read_value_ff, rsp_read_value_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;
   logic [WORD_W-1:0]        rsp_evicted_key_ff, rsp_evicted_key_in;

   logic [CMP_W-1:0]         cap_eff;
   logic [WORD_W-1:0]        clock_next;
   logic [WORD_W-1:0]        count_next;
   logic                     need_evict;
   logic [MAX_ENTRIES-1:0]   valid_kept;
   logic                     free_found;
   logic [IDX_W-1:0]         free_idx;

   assign cap_eff = (CMP_W'(cap) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : CMP_W'(cap);
   assign clock_next = (clock_ff == SAT_MAX) ? clock_ff : clock_ff + 1'b1;
   assign count_next = (scan_res.hit_entry.use_count == SAT_MAX) ?
                       scan_res.hit_entry.use_count : scan_res.hit_entry.use_count + 1'b1;
   assign need_evict = (CMP_W'(fill_ff) >= cap_eff) && scan_res.vic_found;

   // valid bits once the victim (if any) is dropped
   always_comb begin
      valid_kept = valid_ff;
      if (need_evict) begin
         valid_kept[scan_res.vic_idx] = 1'b0;
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_kept[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      valid_in           = valid_ff;
      fill_in            = fill_ff;
      clock_in           = clock_ff;
      func_in            = func_ff;
      key_in             = key_ff;
      value_in           = value_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      ram_we             = 1'b0;
      ram_waddr          = scan_res.hit_idx;
      ram_wdata          = scan_res.hit_entry;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key;
               value_in = req_value;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == FILL_W'(MAX_ENTRIES)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in           = ST_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_hit_in         = scan_res.hit;
               rsp_read_value_in  = '0;
               rsp_evicted_in     = 1'b0;
               rsp_evicted_key_in = '0;
               ram_wdata.use_count = count_next;
               ram_wdata.stamp     = clock_ff;
               if (func_ff == FUNC_GET) begin
                  if (scan_res.hit) begin
                     rsp_read_value_in = scan_res.hit_entry.data;
                     ram_we            = 1'b1;
                     clock_in          = clock_next;
                  end else begin
                     rsp_read_value_in = MISS_VALUE;
                  end
               end else if (cap_eff != '0) begin
                  if (scan_res.hit) begin
                     ram_wdata.data = value_ff;
                     ram_we         = 1'b1;
                     clock_in       = clock_next;
                  end else begin
                     rsp_evicted_in     = need_evict;
                     rsp_evicted_key_in = need_evict ? scan_res.vic_entry.key : '0;
                     valid_in           = valid_kept;
                     if (free_found) begin
                        valid_in[free_idx]  = 1'b1;
                        ram_we              = 1'b1;
                        ram_waddr           = free_idx;
                        ram_wdata.key       = key_ff;
                        ram_wdata.data      = value_ff;
                        ram_wdata.use_count = WORD_W'(1);
                        clock_in            = clock_next;
                     end
                     fill_in = fill_ff - FILL_W'(need_evict) + FILL_W'(free_found);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff             <= cnt_in;
      func_ff            <= func_in;
      key_ff             <= key_in;
      value_ff           <= value_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fill_ff      <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan issue: address cnt goes out, data for cnt-1 comes back
   assign ram_raddr      = cnt_ff[IDX_W-1:0];
   assign scan_ctl.clear = (state_ff == ST_IDLE) && req_valid;
   assign scan_ctl.load  = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign scan_ctl.idx   = IDX_W'(cnt_ff - 1'b1);
   assign scan_valid     = valid_ff[scan_ctl.idx];
   assign scan_key       = key_ff;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

[design/lfu_cache_table_core.sv]
// Sequence: once a request is accepted, the scan reads every slot through the
// slot memory read port, then a write-back step loads the result register.
// A new transaction is taken only after the previous one returns to idle;
// the single-ported scan of all slots through the memory bounds the rate.
// Reset (synchronous, active high): all slots invalid, fill level and access
// clock zero, capacity 16; slot memory contents are not cleared.
// ----------------------------------------------------------------------------
// lfu_cache_table_core: key/value cache with LFU replacement
// Slot key, data, use count and recency stamp live in one synchronous RAM;
// valid bits, fill level and the access clock live in flip-flops.
// ----------------------------------------------------------------------------
module lfu_cache_table_core import lct_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // capacity register write
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic signed [WORD_W-1:0] req_lookup_key,
   input  logic signed [WORD_W-1:0] req_store_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic signed [WORD_W-1:0] rsp_read_value,
   output logic                     rsp_evicted,
   output logic signed [WORD_W-1:0] rsp_evicted_key
);

   logic [CAP_W-1:0]  cap_ff;
   logic [CAP_W-1:0]  cap_in;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type         rd_entry;

   scan_ctl_type      scan_ctl;
   scan_res_type      scan_res;
   logic              scan_valid;
   logic [WORD_W-1:0] scan_key;

   logic [WORD_W-1:0] read_value_raw;
   logic [WORD_W-1:0] evicted_key_raw;

   // capacity register; the user must write it only between transactions (not enforced)
   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // slot storage: one entry per slot, read once per scan cycle
   lct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // key match and LFU/LRU victim tracking over the scan
   lct_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_ctl   (scan_ctl),
      .slot_valid (scan_valid),
      .rd_entry   (rd_entry),
      .lookup_key (scan_key),
      .scan_res   (scan_res)
   );

   // sequencing, write-back and response register
   lct_control u_control (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key         (WORD_W'(req_lookup_key)),
      .req_value       (WORD_W'(req_store_value)),
      .cap             (cap_ff),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .scan_ctl        (scan_ctl),
      .scan_valid      (scan_valid),
      .scan_key        (scan_key),
      .scan_res        (scan_res),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (read_value_raw),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (evicted_key_raw)
   );

   assign rsp_read_value  = signed'(read_value_raw);
   assign rsp_evicted_key = signed'(evicted_key_raw);

endmodule
